// ----- sv/mklm_pkg.sv -----
`timescale 1ns / 1ps

package mklm_pkg;

	// keyword geometry
	localparam int MAX_KW      = 4;
	localparam int KW_CHARS    = 8;
	localparam int KW_REGS     = 4;
	localparam int KW_SEL_W    = $clog2(KW_REGS);
	localparam int KW_LEN_W    = $clog2(KW_CHARS + 1);
	localparam int HIST_W      = 8 * KW_CHARS;

	// register port and result widths
	localparam int KW_W        = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CNT_W       = 3;
	localparam int LINE_W      = 16;
	localparam int MASK_W      = 4;

	// queue between front and back, depth 2 or more
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// character codes
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEYWORD_0     = 3'd0,
		REG_KEYWORD_1     = 3'd1,
		REG_KEYWORD_2     = 3'd2,
		REG_KEYWORD_3     = 3'd3,
		REG_KEYWORD_COUNT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_number;
		logic [MASK_W-1:0] found_mask;
		logic              all_found;
	} out_word_t;

	// classified word held in the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       keep;
		logic       line_end;
	} item_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
		logic               full;
		logic               empty;
	} queue_status_t;

	// fold a-z to upper case
	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ----- sv/mklm_front.sv -----
`timescale 1ns / 1ps

module mklm_front import mklm_pkg::*; (
	input  logic          in_valid,
	output logic          in_stall,
	input  in_word_t      in_data,
	input  queue_status_t q_stat,
	output logic          push,
	output item_t         push_item
);

	logic keep;

	// drop spaces and empty words, fold the rest
	assign keep = in_data.byte_valid && (in_data.text_byte != CHAR_SPACE);

	assign push_item.ch       = fold_char(in_data.text_byte);
	assign push_item.keep     = keep;
	assign push_item.line_end = in_data.line_end;

	// words that change nothing are taken but not queued
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full && (keep || in_data.line_end);

endmodule

// ----- sv/mklm_queue.sv -----
`timescale 1ns / 1ps

module mklm_queue import mklm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         push_item,
	input  logic          pop,
	output item_t         head,
	output queue_status_t q_stat
);

	item_t               entry_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.count = count_q;
	assign q_stat.full  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/mklm_back.sv -----
`timescale 1ns / 1ps

module mklm_back import mklm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]      cfg_data,
	input  logic                 head_valid,
	input  item_t                head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data
);

	// keywords, stored folded with their length
	logic [KW_CHARS-1:0][7:0] kw_q [KW_REGS];
	logic [KW_LEN_W-1:0]      len_q [KW_REGS];
	logic [CNT_W-1:0]         used_q;

	logic [KW_CHARS-1:0][7:0] cfg_fold;
	logic [KW_LEN_W-1:0]      cfg_len;

	// line state
	logic [HIST_W-1:0]   hist_q;
	logic [KW_LEN_W-1:0] seen_q;
	logic [MASK_W-1:0]   flags_q;
	logic [LINE_W-1:0]   line_q;

	logic [HIST_W-1:0]   hist_next;
	logic [KW_LEN_W-1:0] seen_next;
	logic [MASK_W-1:0]   hit;
	logic [MASK_W-1:0]   flags_next;
	logic [MASK_W-1:0]   want;
	logic [MASK_W-1:0]   empty_kw;
	logic [MASK_W-1:0]   mask;
	logic [LINE_W-1:0]   line_next;

	logic      out_valid_q;
	out_word_t out_data_q;

	// fold the written keyword and find its first zero byte
	always_comb begin
		logic ended;
		ended   = 1'b0;
		cfg_len = '0;
		for (int i = 0; i < KW_CHARS; i++) begin
			cfg_fold[i] = fold_char(cfg_data[8*i +: 8]);
			if (cfg_data[8*i +: 8] == 8'h00) begin
				ended = 1'b1;
			end else if (!ended) begin
				cfg_len = cfg_len + 1'b1;
			end
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KW_REGS; k++) begin
				kw_q[k]  <= '0;
				len_q[k] <= '0;
			end
			used_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEYWORD_0, REG_KEYWORD_1, REG_KEYWORD_2, REG_KEYWORD_3: begin
					kw_q[cfg_index[KW_SEL_W-1:0]]  <= cfg_fold;
					len_q[cfg_index[KW_SEL_W-1:0]] <= cfg_len;
				end
				REG_KEYWORD_COUNT: begin
					used_q <= (cfg_data[CNT_W-1:0] > CNT_W'(MAX_KW)) ?
						CNT_W'(MAX_KW) : cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// history shift and parallel compare against every keyword
	always_comb begin
		logic eq;
		hist_next = hist_q;
		seen_next = seen_q;
		if (head.keep) begin
			hist_next = (hist_q << 8) | HIST_W'(head.ch);
			if (seen_q < KW_LEN_W'(KW_CHARS)) begin
				seen_next = seen_q + 1'b1;
			end
		end
		hit      = '0;
		want     = '0;
		empty_kw = '0;
		for (int k = 0; k < MAX_KW; k++) begin
			if (CNT_W'(k) < used_q) begin
				want[k]     = 1'b1;
				empty_kw[k] = (len_q[k] == '0);
			end
			for (int l = 1; l <= KW_CHARS; l++) begin
				eq = 1'b1;
				for (int i = 0; i < l; i++) begin
					if (kw_q[k][i] != hist_next[8*(l-1-i) +: 8]) begin
						eq = 1'b0;
					end
				end
				if (head.keep && want[k] && len_q[k] == KW_LEN_W'(l) &&
				    seen_next >= len_q[k] && eq) begin
					hit[k] = 1'b1;
				end
			end
		end
		flags_next = flags_q | hit;
		mask       = (flags_next | empty_kw) & want;
		line_next  = (line_q == '1) ? line_q : line_q + 1'b1;
	end

	// a line end waits until the output register is free
	assign pop = head_valid && (!head.line_end || !out_valid_q || !out_stall);

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			seen_q  <= '0;
			flags_q <= '0;
			line_q  <= '0;
		end else if (pop) begin
			if (head.line_end) begin
				hist_q  <= '0;
				seen_q  <= '0;
				flags_q <= '0;
				line_q  <= line_next;
			end else begin
				hist_q  <= hist_next;
				seen_q  <= seen_next;
				flags_q <= flags_next;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.line_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (pop && head.line_end) begin
			out_data_q.line_number <= line_next;
			out_data_q.found_mask  <= mask;
			out_data_q.all_found   <= (mask == want);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- sv/multi_keyword_line_matcher_core.sv -----
`timescale 1ns / 1ps

// Multi-keyword line matcher.
// Input channel (in_valid / in_stall / in_data) carries one text byte per word;
// line_end marks the last word of a line. Spaces are dropped and a-z folded.
// Output channel (out_valid / out_stall / out_data) gives one word per line:
// line number (saturating), mask of keywords found, and an all-found flag.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the four
// keywords and the keyword count; cfg_ready is always high. Write it only
// while no line is in flight.
// Throughput: one input word per cycle while in_stall is low, set by the history
// shift and the parallel compare of all keywords in the back end.
// A line end passes through the two-entry queue, then the output register,
// before it shows on out_valid.
// Reset clears keywords, count, line state and the line counter; no output.
// When the receiver stalls, the output word holds; the queue keeps taking
// words until it is full, then in_stall rises.
module multi_keyword_line_matcher_core import mklm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]      cfg_data
);

	queue_status_t q_stat;
	logic          push;
	item_t         push_item;
	logic          pop;
	item_t         head;

	assign cfg_ready = 1'b1;

	mklm_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	mklm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	mklm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (!q_stat.empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

`ifndef ASSERT_OFF
	// back end never takes from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// front end never writes a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("push into full queue");

	// fill count stays within the queue depth
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= Q_CNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	// every result carries a one-based line number
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.line_number != '0)
		else $error("result with line number zero");
`endif

endmodule

// ----- test/multi_keyword_line_matcher_core_test.sv -----
`timescale 1ns / 1ps

import mklm_pkg::*;

// tracks keyword state and the line results the core should give
class line_scoreboard;
	logic [KW_W-1:0]   keyword [MAX_KW];
	logic [CNT_W-1:0]  kw_count;
	logic [HIST_W-1:0] history;
	int unsigned       kept;
	logic [MASK_W-1:0] hits;
	logic [LINE_W-1:0] line_cnt;
	out_word_t         expected_q[$];
	int unsigned       errors;
	int unsigned       results_checked;

	function new();
		for (int k = 0; k < MAX_KW; k++) begin
			keyword[k] = '0;
		end
		kw_count = '0;
		history = '0;
		kept = 0;
		hits = '0;
		line_cnt = '0;
		errors = 0;
		results_checked = 0;
	endfunction

	// a-z to upper case
	function logic [7:0] upcase(logic [7:0] c);
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	function int kw_length(int k);
		int n;
		n = 0;
		while (n < KW_CHARS && keyword[k][8*n +: 8] != 8'h00) begin
			n++;
		end
		return n;
	endfunction

	function int used_count();
		return (kw_count > MAX_KW) ? MAX_KW : int'(kw_count);
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KW_W-1:0] d);
		if (idx <= REG_KEYWORD_3) begin
			keyword[idx[KW_SEL_W-1:0]] = d;
		end else if (idx == REG_KEYWORD_COUNT) begin
			kw_count = d[CNT_W-1:0];
		end
	endfunction

	// shift one folded char into the history and compare every keyword tail
	function void take_char(logic [7:0] c);
		int len;
		bit hit;
		history = {history[HIST_W-9:0], c};
		if (kept < KW_CHARS) begin
			kept++;
		end
		for (int k = 0; k < used_count(); k++) begin
			len = kw_length(k);
			if (len == 0 || kept < len) begin
				continue;
			end
			hit = 1'b1;
			for (int i = 0; i < len; i++) begin
				if (upcase(keyword[k][8*i +: 8]) != history[8*(len-1-i) +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				hits[k] = 1'b1;
			end
		end
	endfunction

	// accepted input word: update line state, queue a result at line end
	function void note_word(in_word_t w);
		int n;
		logic [MASK_W:0] want;
		logic [MASK_W-1:0] mask;
		out_word_t res;
		if (w.byte_valid && w.text_byte != CHAR_SPACE) begin
			take_char(upcase(w.text_byte));
		end
		if (!w.line_end) begin
			return;
		end
		n = used_count();
		want = ({{MASK_W{1'b0}}, 1'b1} << n) - 1'b1;
		mask = hits;
		for (int k = 0; k < n; k++) begin
			if (kw_length(k) == 0) begin
				mask[k] = 1'b1;
			end
		end
		mask &= want[MASK_W-1:0];
		if (line_cnt != {LINE_W{1'b1}}) begin
			line_cnt++;
		end
		res.line_number = line_cnt;
		res.found_mask = mask;
		res.all_found = (mask == want[MASK_W-1:0]);
		expected_q.push_back(res);
		history = '0;
		kept = 0;
		hits = '0;
	endfunction

	task report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	task check_result(out_word_t got);
		out_word_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result for line %0d with none pending", got.line_number));
			return;
		end
		want = expected_q.pop_front();
		results_checked++;
		if (got.line_number != want.line_number) begin
			report($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
		end
		if (got.found_mask != want.found_mask) begin
			report($sformatf("line %0d found_mask %b, want %b", want.line_number,
				got.found_mask, want.found_mask));
		end
		if (got.all_found != want.all_found) begin
			report($sformatf("line %0d all_found %b, want %b", want.line_number,
				got.all_found, want.all_found));
		end
	endtask
endclass

module multi_keyword_line_matcher_core_test;

	// random phases stop here; the directed start and the quiet tail add the rest
	localparam int ITEMS_TARGET = 1350;
	localparam int QUIET_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 60;
	localparam int SETTLE_WAIT  = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KW_W-1:0]      cfg_data;

	line_scoreboard sb = new();

	logic [KW_W-1:0] cur_kw [MAX_KW];
	logic [7:0]      line_q[$];
	bit              idle_on;
	bit              stall_on;
	bit              hold_req;
	int unsigned     words_sent;
	int unsigned     lines_sent;
	int unsigned     reg_writes;
	int unsigned     quiet;

	multi_keyword_line_matcher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (in_valid && !in_stall) begin
			sb.note_word(in_data);
		end
		if (out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
		if (cfg_valid && cfg_ready) begin
			sb.write_reg(cfg_index, cfg_data);
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [KW_W-1:0] pack_kw(string s);
		logic [KW_W-1:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < KW_CHARS; i++) begin
			v[8*i +: 8] = s[i];
		end
		return v;
	endfunction

	// letter from a small alphabet in either case
	function automatic logic [7:0] rand_letter(int span);
		logic [7:0] c;
		c = CHAR_LOWER_A + 8'($urandom_range(0, span - 1));
		if ($urandom_range(0, 1) == 1) begin
			c = c - CASE_OFFSET;
		end
		return c;
	endfunction

	// keyword value: short words mostly, garbage past the zero byte
	function automatic logic [KW_W-1:0] rand_keyword();
		logic [KW_W-1:0] v;
		int len;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return {$urandom, $urandom};
		end
		if (r == 1) begin
			return '0;
		end
		if (r == 2) begin
			return '1;
		end
		len = $urandom_range(1, (r == 3) ? KW_CHARS : 5);
		v = {$urandom, $urandom};
		for (int i = 0; i < KW_CHARS; i++) begin
			if (i < len) begin
				v[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255))
					: rand_letter(4);
			end else if (i == len) begin
				v[8*i +: 8] = 8'h00;
			end
		end
		return v;
	endfunction

	function automatic logic [KW_W-1:0] rand_reg_value(cfg_reg_t idx);
		int c;
		if (idx == REG_KEYWORD_COUNT) begin
			c = $urandom_range(0, 9);
			if (c > 7) begin
				c -= 6;
			end
			return KW_W'(c);
		end
		return rand_keyword();
	endfunction

	task write_reg(cfg_reg_t idx, logic [KW_W-1:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_KEYWORD_3) begin
			cur_kw[idx[KW_SEL_W-1:0]] = d;
		end
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one input word, with an occasional idle burst first
	task send_word(logic [7:0] b, bit v, bit e);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.text_byte = b;
		in_data.byte_valid = v;
		in_data.line_end = e;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (e) begin
			lines_sent++;
		end
	endtask

	// drop valid and let every pending line drain before touching registers
	task settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	// line text: filler and current keywords in mixed case with spaces mixed in
	task make_line();
		int k;
		logic [7:0] b;
		line_q.delete();
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 1) == 1) begin
				k = $urandom_range(0, MAX_KW - 1);
				for (int i = 0; i < KW_CHARS; i++) begin
					b = cur_kw[k][8*i +: 8];
					if (b == 8'h00) begin
						break;
					end
					if ($urandom_range(0, 1) == 1) begin
						if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
							b = b - CASE_OFFSET;
						end else if (b >= CHAR_LOWER_A - CASE_OFFSET
							&& b <= CHAR_LOWER_Z - CASE_OFFSET) begin
							b = b + CASE_OFFSET;
						end
					end
					line_q.push_back(b);
					if ($urandom_range(0, 5) == 0) begin
						line_q.push_back(CHAR_SPACE);
					end
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 9))
						0:       line_q.push_back(CHAR_SPACE);
						1, 2:    line_q.push_back(8'($urandom_range(0, 255)));
						default: line_q.push_back(rand_letter(5));
					endcase
				end
			end
		end
	endtask

	// send line_q, empty words sprinkled in; optionally rewrite a register mid-line
	task send_line(bit mid_cfg);
		bit end_on_byte;
		cfg_reg_t idx;
		end_on_byte = $urandom_range(0, 1);
		for (int i = 0; i < line_q.size(); i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_word(8'($urandom), 1'b0, 1'b0);
			end
			if (mid_cfg && i == line_q.size() / 2) begin
				settle();
				idx = cfg_reg_t'($urandom_range(0, 4));
				write_reg(idx, rand_reg_value(idx));
			end
			send_word(line_q[i], 1'b1, end_on_byte && i == line_q.size() - 1);
		end
		if (!end_on_byte || line_q.size() == 0) begin
			send_word(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b0;
		stall_on = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		lines_sent = 0;
		reg_writes = 0;
		quiet = 0;
		phase = 0;
		for (int k = 0; k < MAX_KW; k++) begin
			cur_kw[k] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no keywords after reset: every line matches
		send_word(8'h41, 1'b0, 1'b1);

		// lower-case keyword, empty keyword, keyword with a space, full-width keyword,
		// count above the maximum
		settle();
		write_reg(REG_KEYWORD_0, pack_kw("ab"));
		write_reg(REG_KEYWORD_1, '0);
		write_reg(REG_KEYWORD_2, pack_kw("X Y"));
		write_reg(REG_KEYWORD_3, pack_kw("ABCDEFGH"));
		write_reg(REG_KEYWORD_COUNT, KW_W'(7));
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h42, 1'b1, 1'b1);
		line_q = '{8'h61, 8'h62, 8'h63, CHAR_SPACE, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68};
		foreach (line_q[i]) send_word(line_q[i], 1'b1, 1'b0);
		send_word(8'hff, 1'b0, 1'b1);

		// all-ones keyword against a run of 0xff bytes
		settle();
		write_reg(REG_KEYWORD_2, '1);
		for (int i = 0; i < KW_CHARS; i++) begin
			send_word(8'hff, 1'b1, i == KW_CHARS - 1);
		end

		// count changed mid-line, then a zero text byte ends the line
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		settle();
		write_reg(REG_KEYWORD_COUNT, KW_W'(1));
		send_word(8'h00, 1'b1, 1'b1);

		// random phases with fresh settings each time
		while (words_sent < ITEMS_TARGET) begin
			phase++;
			settle();
			for (int r = 0; r <= REG_KEYWORD_COUNT; r++) begin
				if ($urandom_range(0, 2) != 0) begin
					write_reg(cfg_reg_t'(r), rand_reg_value(cfg_reg_t'(r)));
				end
			end
			idle_on = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			if (phase == 3) begin
				hold_req = 1'b1;
			end
			repeat ($urandom_range(4, 14)) begin
				make_line();
				send_line($urandom_range(0, 11) == 0);
			end
		end

		// last part, no idling on either side
		settle();
		idle_on = 1'b0;
		stall_on = 1'b0;
		write_reg(REG_KEYWORD_0, pack_kw("a"));
		write_reg(REG_KEYWORD_COUNT, KW_W'(1));
		repeat (5) begin
			make_line();
			send_line(1'b0);
		end
		settle();

		$display("run: %0d input words, %0d line results checked, %0d register writes",
			words_sent, sb.results_checked, reg_writes);
		$display("run: %0d random phases, keyword corner cases, mid-line rewrites, %s",
			phase, "long output hold-off");
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/mklm_pkg.sv
sv/mklm_front.sv
sv/mklm_queue.sv
sv/mklm_back.sv
sv/multi_keyword_line_matcher_core.sv
test/multi_keyword_line_matcher_core_test.sv
